>>> sv/vrap_pkg.sv
// ----------------------------------------------------------------------------
// vrap_pkg
// Shared constants and types for the vertex rotate-about-point pipeline.
// ----------------------------------------------------------------------------
package vrap_pkg;

    localparam int POS_WIDTH_DEF  = 24;
    localparam int NORM_WIDTH_DEF = 16;

    // Matrix coefficients are signed Q1.14, three to a 48-bit row register.
    localparam int COEF_W = 16;
    localparam int ROW_W  = 3 * COEF_W;
    localparam logic [COEF_W-1:0] ONE_Q14 = 16'h4000;

    // Fraction bits dropped when the position product is rounded back.
    localparam int POS_RND_SH = 14;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = ROW_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ROT_ROW_0 = 3'd0,
        CFG_ROT_ROW_1 = 3'd1,
        CFG_ROT_ROW_2 = 3'd2,
        CFG_PIVOT_X   = 3'd3,
        CFG_PIVOT_Y   = 3'd4,
        CFG_PIVOT_Z   = 3'd5
    } cfg_index_t;

endpackage

>>> sv/vertex_rotate_about_point.sv
// ----------------------------------------------------------------------------
// vertex_rotate_about_point
// Rotates a vertex position about a pivot and rotates and renormalizes its
// normal, one vertex per clock while the output skid is empty, fully pipelined.
// ----------------------------------------------------------------------------
//  Channel | Signals                                   | Direction
//  --------+-------------------------------------------+-----------
//  in      | in_valid, in_ready, pos_*, norm_*, last_in | request in
//  out     | out_valid, out_ready, out_*, last_out      | request out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | write in
//
//  One request is taken per cycle while the skid register is empty. The
//  pipeline length is set by the square root (one root bit per stage) and
//  the divider (one quotient bit per stage). Reset clears all valid bits
//  and loads the identity matrix and a zero pivot. A stalled output parks
//  one result in a skid register; the pipeline stops only once that
//  register is full.
// ----------------------------------------------------------------------------
module vertex_rotate_about_point #(
    parameter int POS_WIDTH  = vrap_pkg::POS_WIDTH_DEF,
    parameter int NORM_WIDTH = vrap_pkg::NORM_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [POS_WIDTH-1:0]         pos_x,
    input  logic signed [POS_WIDTH-1:0]         pos_y,
    input  logic signed [POS_WIDTH-1:0]         pos_z,
    input  logic signed [NORM_WIDTH-1:0]        norm_x,
    input  logic signed [NORM_WIDTH-1:0]        norm_y,
    input  logic signed [NORM_WIDTH-1:0]        norm_z,
    input  logic                                last_in,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [POS_WIDTH-1:0]         out_pos_x,
    output logic signed [POS_WIDTH-1:0]         out_pos_y,
    output logic signed [POS_WIDTH-1:0]         out_pos_z,
    output logic signed [NORM_WIDTH-1:0]        out_norm_x,
    output logic signed [NORM_WIDTH-1:0]        out_norm_y,
    output logic signed [NORM_WIDTH-1:0]        out_norm_z,
    output logic                                last_out,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vrap_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [vrap_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import vrap_pkg::*;

    localparam int PW  = POS_WIDTH;
    localparam int NW  = NORM_WIDTH;
    localparam int CW  = COEF_W;
    localparam int DW  = PW + 1;          // p - pivot
    localparam int PMW = CW + DW;         // one position product
    localparam int AW  = PMW + 2;         // position dot product
    localparam int NMW = CW + NW;         // one normal product
    localparam int VW  = NMW + 2;         // normal dot product
    localparam int SH  = NW - 12;         // normal pre-shift
    localparam int UW  = VW - SH;         // shifted normal component
    localparam int SW  = 2 * UW;          // sum of squares
    localparam int LW  = UW;              // square root
    localparam int QW  = NW - 1;          // quotient magnitude
    localparam int NRW = UW + NW;         // divider remainder

    typedef struct packed {
        logic                   last;
        logic [2:0][PW-1:0]     pos;
        logic [2:0]             neg;
        logic [2:0][UW-1:0]     mag;
        logic [SW-1:0]          rem;
        logic [LW-1:0]          root;
    } sq_t;

    typedef struct packed {
        logic                   last;
        logic [2:0][PW-1:0]     pos;
        logic [2:0]             neg;
        logic                   zero;
        logic [2:0][NRW-1:0]    rem;
        logic [2:0][QW-1:0]     quo;
        logic [LW:0]            den;
    } dv_t;

    typedef struct packed {
        logic                   last;
        logic [2:0][PW-1:0]     pos;
        logic [2:0][NW-1:0]     norm;
    } res_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] row_reg [3];
    logic [PW-1:0]    piv_reg [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW_W'(ONE_Q14) << (2 * CW);
            row_reg[1] <= ROW_W'(ONE_Q14) << CW;
            row_reg[2] <= ROW_W'(ONE_Q14);
            piv_reg[0] <= '0;
            piv_reg[1] <= '0;
            piv_reg[2] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ROT_ROW_0: row_reg[0] <= cfg_data[ROW_W-1:0];
                CFG_ROT_ROW_1: row_reg[1] <= cfg_data[ROW_W-1:0];
                CFG_ROT_ROW_2: row_reg[2] <= cfg_data[ROW_W-1:0];
                CFG_PIVOT_X:   piv_reg[0] <= cfg_data[PW-1:0];
                CFG_PIVOT_Y:   piv_reg[1] <= cfg_data[PW-1:0];
                CFG_PIVOT_Z:   piv_reg[2] <= cfg_data[PW-1:0];
                default:       ;
            endcase
        end
    end

    logic signed [CW-1:0] coef [3][3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                coef[i][j] = row_reg[i][ROW_W-1-CW*j -: CW];
    end

    // ------------------------------------------------------------------
    // Pipeline enable and output skid
    // ------------------------------------------------------------------
    logic en;
    logic skid_v_reg;
    logic out_v_reg;

    assign en       = !skid_v_reg;
    assign in_ready = en;

    // ------------------------------------------------------------------
    // Stage 0: subtract the pivot
    // ------------------------------------------------------------------
    logic signed [PW-1:0] pos_in  [3];
    logic signed [NW-1:0] norm_in [3];
    logic signed [DW-1:0] d_next  [3];
    logic signed [DW-1:0] d_reg   [3];
    logic signed [NW-1:0] n_reg   [3];
    logic                 last0_reg;
    logic                 v0_reg;

    assign pos_in[0]  = pos_x;
    assign pos_in[1]  = pos_y;
    assign pos_in[2]  = pos_z;
    assign norm_in[0] = norm_x;
    assign norm_in[1] = norm_y;
    assign norm_in[2] = norm_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            d_next[i] = $signed({pos_in[i][PW-1], pos_in[i]})
                      - $signed({piv_reg[i][PW-1], piv_reg[i]});
    end

    // ------------------------------------------------------------------
    // Stage 1: nine products for the position and nine for the normal
    // ------------------------------------------------------------------
    logic signed [PMW-1:0] pm_next [3][3];
    logic signed [NMW-1:0] nm_next [3][3];
    logic signed [PMW-1:0] pm_reg  [3][3];
    logic signed [NMW-1:0] nm_reg  [3][3];
    logic                  last1_reg;
    logic                  v1_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                pm_next[i][j] = coef[i][j] * d_reg[j];
                nm_next[i][j] = coef[i][j] * n_reg[j];
            end
    end

    // ------------------------------------------------------------------
    // Stage 2: dot products
    // ------------------------------------------------------------------
    logic signed [AW-1:0] acc_next [3];
    logic signed [VW-1:0] vn_next  [3];
    logic signed [AW-1:0] acc_reg  [3];
    logic signed [VW-1:0] vn_reg   [3];
    logic                 last2_reg;
    logic                 v2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_next[i] = AW'(pm_reg[i][0]) + AW'(pm_reg[i][1]) + AW'(pm_reg[i][2]);
            vn_next[i]  = VW'(nm_reg[i][0]) + VW'(nm_reg[i][1]) + VW'(nm_reg[i][2]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: round, add the pivot back, saturate; pre-shift the normal
    // ------------------------------------------------------------------
    localparam logic signed [AW-1:0] PMAX = {{(AW-PW+1){1'b0}}, {(PW-1){1'b1}}};
    localparam logic signed [AW-1:0] PMIN = {{(AW-PW+1){1'b1}}, {(PW-1){1'b0}}};
    localparam logic signed [AW-1:0] HALF = AW'(1) << (POS_RND_SH - 1);

    logic signed [AW-1:0] rnd      [3];
    logic signed [AW-1:0] psum     [3];
    logic [PW-1:0]        pos_next [3];
    logic signed [UW-1:0] u_next   [3];
    logic [PW-1:0]        pos3_reg [3];
    logic signed [UW-1:0] u_reg    [3];
    logic                 last3_reg;
    logic                 v3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd[i]  = (acc_reg[i] + HALF) >>> POS_RND_SH;
            psum[i] = rnd[i] + AW'($signed(piv_reg[i]));
            if (psum[i] > PMAX)
                pos_next[i] = PMAX[PW-1:0];
            else if (psum[i] < PMIN)
                pos_next[i] = PMIN[PW-1:0];
            else
                pos_next[i] = psum[i][PW-1:0];
            // Dropping the low bits is a floor shift.
            u_next[i] = vn_reg[i][VW-1:SH];
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: squares, sign and magnitude
    // ------------------------------------------------------------------
    logic signed [SW-1:0] sqp       [3];
    logic [SW-1:0]        sqr_reg   [3];
    logic [UW-1:0]        mag_next  [3];
    logic [UW-1:0]        mag_reg   [3];
    logic [2:0]           neg_reg;
    logic [PW-1:0]        pos4_reg  [3];
    logic                 last4_reg;
    logic                 v4_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sqp[i]      = u_reg[i] * u_reg[i];
            mag_next[i] = u_reg[i][UW-1] ? UW'(-u_reg[i]) : UW'(u_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last0_reg <= last_in;
            last1_reg <= last0_reg;
            last2_reg <= last1_reg;
            last3_reg <= last2_reg;
            last4_reg <= last3_reg;
            for (int i = 0; i < 3; i++)
            begin
                d_reg[i]    <= d_next[i];
                n_reg[i]    <= norm_in[i];
                for (int j = 0; j < 3; j++)
                begin
                    pm_reg[i][j] <= pm_next[i][j];
                    nm_reg[i][j] <= nm_next[i][j];
                end
                acc_reg[i]  <= acc_next[i];
                vn_reg[i]   <= vn_next[i];
                pos3_reg[i] <= pos_next[i];
                u_reg[i]    <= u_next[i];
                sqr_reg[i]  <= $unsigned(sqp[i]);
                mag_reg[i]  <= mag_next[i];
                neg_reg[i]  <= u_reg[i][UW-1];
                pos4_reg[i] <= pos3_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Square root, one root bit per stage
    // ------------------------------------------------------------------
    sq_t  sq_reg   [LW+1];
    logic sq_v_reg [LW+1];
    sq_t  sq_first;

    always_comb
    begin
        sq_first.last = last4_reg;
        sq_first.neg  = neg_reg;
        for (int i = 0; i < 3; i++)
        begin
            sq_first.pos[i] = pos4_reg[i];
            sq_first.mag[i] = mag_reg[i];
        end
        sq_first.rem  = sqr_reg[0] + sqr_reg[1] + sqr_reg[2];
        sq_first.root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg[0] <= 1'b0;
        else if (en)
            sq_v_reg[0] <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sq_reg[0] <= sq_first;
    end

    for (genvar j = 0; j < LW; j++)
    begin : g_sqrt
        localparam int B = LW - 1 - j;
        sq_t         nxt;
        logic [SW:0] test;

        always_comb
        begin
            nxt  = sq_reg[j];
            // Candidate (2*root + 2^B) * 2^B against the running remainder.
            test = ({1'b0, SW'(sq_reg[j].root)} << (B + 1)) + ((SW + 1)'(1) << (2 * B));
            if ({1'b0, sq_reg[j].rem} >= test)
            begin
                nxt.rem     = sq_reg[j].rem - test[SW-1:0];
                nxt.root[B] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_v_reg[j+1] <= 1'b0;
            else if (en)
                sq_v_reg[j+1] <= sq_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                sq_reg[j+1] <= nxt;
        end
    end

    // ------------------------------------------------------------------
    // Divider: round(|u| * 2^(NW-2) / L) as floor((2|u|*2^(NW-2) + L) / 2L)
    // ------------------------------------------------------------------
    dv_t  dv_reg   [QW+1];
    logic dv_v_reg [QW+1];
    dv_t  dv_first;

    always_comb
    begin
        dv_first.last = sq_reg[LW].last;
        dv_first.pos  = sq_reg[LW].pos;
        dv_first.neg  = sq_reg[LW].neg;
        dv_first.zero = (sq_reg[LW].root == '0);
        dv_first.den  = {sq_reg[LW].root, 1'b0};
        for (int i = 0; i < 3; i++)
        begin
            dv_first.rem[i] = (NRW'(sq_reg[LW].mag[i]) << (NW - 1))
                            + NRW'(sq_reg[LW].root);
            dv_first.quo[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg[0] <= 1'b0;
        else if (en)
            dv_v_reg[0] <= sq_v_reg[LW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dv_reg[0] <= dv_first;
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        localparam int B = QW - 1 - j;
        dv_t            nxt;
        logic [NRW-1:0] sub;

        always_comb
        begin
            nxt = dv_reg[j];
            sub = NRW'(dv_reg[j].den) << B;
            for (int i = 0; i < 3; i++)
            begin
                if (dv_reg[j].rem[i] >= sub)
                begin
                    nxt.rem[i]    = dv_reg[j].rem[i] - sub;
                    nxt.quo[i][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_v_reg[j+1] <= 1'b0;
            else if (en)
                dv_v_reg[j+1] <= dv_v_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                dv_reg[j+1] <= nxt;
        end
    end

    // ------------------------------------------------------------------
    // Sign, zero-length case, output register and skid
    // ------------------------------------------------------------------
    res_t res_next;
    res_t out_reg;
    res_t skid_reg;

    always_comb
    begin
        res_next.last = dv_reg[QW].last;
        res_next.pos  = dv_reg[QW].pos;
        for (int i = 0; i < 3; i++)
        begin
            if (dv_reg[QW].zero)
                res_next.norm[i] = '0;
            else if (dv_reg[QW].neg[i])
                res_next.norm[i] = -NW'(dv_reg[QW].quo[i]);
            else
                res_next.norm[i] = NW'(dv_reg[QW].quo[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (out_ready)
                skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || out_ready)
            out_v_reg <= dv_v_reg[QW];
        else if (dv_v_reg[QW])
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (out_ready)
                out_reg <= skid_reg;
        end
        else if (!out_v_reg || out_ready)
            out_reg <= res_next;
        else
            skid_reg <= res_next;
    end

    assign out_valid  = out_v_reg;
    assign out_pos_x  = out_reg.pos[0];
    assign out_pos_y  = out_reg.pos[1];
    assign out_pos_z  = out_reg.pos[2];
    assign out_norm_x = out_reg.norm[0];
    assign out_norm_y = out_reg.norm[1];
    assign out_norm_z = out_reg.norm[2];
    assign last_out   = out_reg.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    localparam logic signed [NW:0] NLIM = (NW + 1)'(1) << (NW - 2);

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid holds a result while the output register is empty");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && !out_ready))
        else $error("skid filled without an output stall");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(last_out))
        else $error("stalled result changed");

    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        sq_v_reg[LW] |-> ({1'b0, sq_reg[LW].rem} <= ({1'b0, SW'(sq_reg[LW].root)} << 1)))
        else $error("square root remainder out of range");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed({out_norm_x[NW-1], out_norm_x}) <= NLIM)
                   && ($signed({out_norm_x[NW-1], out_norm_x}) >= -NLIM))
        else $error("normal component exceeds unit length");

endmodule

>>> bench/vertex_rotate_about_point_tb.sv
// ----------------------------------------------------------------------------
// vertex_rotate_about_point_tb
// Drives vertices through the rotate-about-point pipeline under several
// matrix and pivot settings. Each accepted request is predicted in the bench
// and checked against the result stream in order. Both sides stall at random, but for one phase.
// ----------------------------------------------------------------------------
module vertex_rotate_about_point_tb;

    import vrap_pkg::*;

    localparam int PW         = 24;
    localparam int NW         = 16;
    localparam int DRAIN      = 80;
    localparam int CYCLE_CAP  = 400000;
    localparam int NUM_PHASES = 10;
    localparam int PHASE_LEN  = 125;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic signed [PW-1:0] px, py, pz;
        logic signed [NW-1:0] nx, ny, nz;
        logic                 last;
    } vertex_t;

    logic clk;
    logic rst_n;
    logic in_valid, in_ready;
    logic signed [PW-1:0] pos_x, pos_y, pos_z;
    logic signed [NW-1:0] norm_x, norm_y, norm_z;
    logic last_in;
    logic out_valid, out_ready;
    logic signed [PW-1:0] out_pos_x, out_pos_y, out_pos_z;
    logic signed [NW-1:0] out_norm_x, out_norm_y, out_norm_z;
    logic last_out;
    logic cfg_valid, cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    vertex_rotate_about_point uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z), .last_in(last_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
        .out_norm_x(out_norm_x), .out_norm_y(out_norm_y), .out_norm_z(out_norm_z),
        .last_out(last_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Bench copy of the matrix and pivot.
    logic [ROW_W-1:0]     mat_row [3];
    logic signed [PW-1:0] pivot   [3];

    vertex_t pending_vertices[$];
    vertex_t rotated_expect[$];
    vertex_t vtx_on_bus;
    int      stall_pct;
    int      cycles;
    bit      failed;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_ROT_ROW_0: mat_row[0] = d;
            CFG_ROT_ROW_1: mat_row[1] = d;
            CFG_ROT_ROW_2: mat_row[2] = d;
            CFG_PIVOT_X:   pivot[0] = d[PW-1:0];
            CFG_PIVOT_Y:   pivot[1] = d[PW-1:0];
            CFG_PIVOT_Z:   pivot[2] = d[PW-1:0];
            default: ;
        endcase
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b >>= 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic vertex_t rotate_vertex(vertex_t v);
        vertex_t res;
        longint  d[3], n[3], u[3], acc, vn, r, c, m, q;
        longint  pmax, pmin;
        longint unsigned s, len;
        pmax = (longint'(1) <<< (PW - 1)) - 1;
        pmin = -pmax - 1;
        d[0] = longint'(v.px) - longint'(pivot[0]);
        d[1] = longint'(v.py) - longint'(pivot[1]);
        d[2] = longint'(v.pz) - longint'(pivot[2]);
        n[0] = v.nx;
        n[1] = v.ny;
        n[2] = v.nz;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            vn = 0;
            for (int j = 0; j < 3; j++)
            begin
                c = $signed(mat_row[i][ROW_W-1-COEF_W*j -: COEF_W]);
                acc += c * d[j];
                vn += c * n[j];
            end
            r = ((acc + 8192) >>> POS_RND_SH) + longint'(pivot[i]);
            if (r > pmax) r = pmax;
            if (r < pmin) r = pmin;
            case (i)
                0: res.px = r[PW-1:0];
                1: res.py = r[PW-1:0];
                default: res.pz = r[PW-1:0];
            endcase
            u[i] = vn >>> (NW - 12);
            s += longint'(u[i] * u[i]);
        end
        len = floor_sqrt(s);
        for (int i = 0; i < 3; i++)
        begin
            q = 0;
            if (s != 0)
            begin
                m = (u[i] < 0) ? -u[i] : u[i];
                m = m <<< (NW - 2);
                q = longint'((2 * longint'(m) + len) / (2 * len));
                if (u[i] < 0) q = -q;
            end
            case (i)
                0: res.nx = q[NW-1:0];
                1: res.ny = q[NW-1:0];
                default: res.nz = q[NW-1:0];
            endcase
        end
        res.last = v.last;
        return res;
    endfunction

    function automatic logic [PW-1:0] rand_pos();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(PW-1){1'b0}}};
            1: return {1'b0, {(PW-1){1'b1}}};
            2: return PW'($signed($urandom_range(0, 16384)) - 8192);
            default: return PW'($urandom);
        endcase
    endfunction

    function automatic logic [NW-1:0] rand_norm();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(NW-1){1'b0}}};
            1: return {1'b0, {(NW-1){1'b1}}};
            2: return NW'($signed($urandom_range(0, 64)) - 32);
            3: return 16'h0000;
            default: return NW'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return ONE_Q14;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic void push_vertex(logic [PW-1:0] x, y, z, logic [NW-1:0] a, b, c,
                                        logic l);
        vertex_t v;
        v = '{px: x, py: y, pz: z, nx: a, ny: b, nz: c, last: l};
        pending_vertices.push_back(v);
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, d);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (pending_vertices.size() != 0 || in_valid || rotated_expect.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    // Input driver: a request holds until taken, then the next one is loaded.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                rotated_expect.push_back(rotate_vertex(vtx_on_bus));
            if (!in_valid || in_ready)
            begin
                if (pending_vertices.size() != 0 && $urandom_range(0, 99) >= stall_pct)
                begin
                    vtx_on_bus = pending_vertices.pop_front();
                    in_valid <= 1'b1;
                    pos_x    <= vtx_on_bus.px;
                    pos_y    <= vtx_on_bus.py;
                    pos_z    <= vtx_on_bus.pz;
                    norm_x   <= vtx_on_bus.nx;
                    norm_y   <= vtx_on_bus.ny;
                    norm_z   <= vtx_on_bus.nz;
                    last_in  <= vtx_on_bus.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and output stall generator.
    always @(posedge clk or negedge rst_n)
    begin
        vertex_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
            if (out_valid && out_ready)
            begin
                if (rotated_expect.size() == 0)
                begin
                    $error("unexpected result");
                    failed = 1'b1;
                end
                else
                begin
                    e = rotated_expect.pop_front();
                    if (out_pos_x !== e.px)
                    begin
                        $error("out_pos_x exp %0d got %0d", e.px, out_pos_x);
                        failed = 1'b1;
                    end
                    if (out_pos_y !== e.py)
                    begin
                        $error("out_pos_y exp %0d got %0d", e.py, out_pos_y);
                        failed = 1'b1;
                    end
                    if (out_pos_z !== e.pz)
                    begin
                        $error("out_pos_z exp %0d got %0d", e.pz, out_pos_z);
                        failed = 1'b1;
                    end
                    if (out_norm_x !== e.nx)
                    begin
                        $error("out_norm_x exp %0d got %0d", e.nx, out_norm_x);
                        failed = 1'b1;
                    end
                    if (out_norm_y !== e.ny)
                    begin
                        $error("out_norm_y exp %0d got %0d", e.ny, out_norm_y);
                        failed = 1'b1;
                    end
                    if (out_norm_z !== e.nz)
                    begin
                        $error("out_norm_z exp %0d got %0d", e.nz, out_norm_z);
                        failed = 1'b1;
                    end
                    if (last_out !== e.last)
                    begin
                        $error("last_out exp %0d got %0d", e.last, last_out);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] row;
        cycles    = 0;
        failed    = 1'b0;
        stall_pct = 25;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ROT_ROW_0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        out_ready = 1'b0;
        {pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, last_in} = '0;
        mat_row[0] = {ONE_Q14, 16'h0, 16'h0};
        mat_row[1] = {16'h0, ONE_Q14, 16'h0};
        mat_row[2] = {16'h0, 16'h0, ONE_Q14};
        pivot[0] = '0;
        pivot[1] = '0;
        pivot[2] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset matrix: extremes of each field, zero normal, sign cases.
        push_vertex(0, 0, 0, 0, 0, 0, 0);
        push_vertex(24'h800000, 24'h7fffff, 24'h800000, 16'h8000, 16'h7fff, 16'h8000, 1);
        push_vertex(24'h7fffff, 24'h800000, 24'h7fffff, 16'h7fff, 16'h8000, 16'h7fff, 0);
        push_vertex(24'h001000, 24'hfff000, 24'h000001, 16'h4000, 0, 0, 1);
        push_vertex(24'hffffff, 24'h000000, 24'h123456, 0, 16'hc000, 0, 0);
        push_vertex(24'h000800, 24'hfff800, 24'h000000, 16'h0001, 16'hffff, 16'h0000, 1);
        push_vertex(24'h3fffff, 24'hc00000, 24'h555555, 16'h2d41, 16'h2d41, 0, 0);
        wait_idle();

        // Saturation: full-scale coefficients of both signs, pivots at the rails, unused indices.
        write_reg(CFG_ROT_ROW_0, {16'h8000, 16'h8000, 16'h8000});
        write_reg(CFG_ROT_ROW_1, {16'h7fff, 16'h7fff, 16'h7fff});
        write_reg(CFG_ROT_ROW_2, {16'h8000, 16'h7fff, 16'h0000});
        write_reg(CFG_PIVOT_X, 48'h0000_007fffff);
        write_reg(CFG_PIVOT_Y, 48'hffff_ff800000);
        write_reg(CFG_PIVOT_Z, 48'h0000_00000000);
        write_reg(CFG_UNUSED_6, '1);
        write_reg(CFG_UNUSED_7, '1);
        push_vertex(24'h800000, 24'h7fffff, 24'h000000, 16'h8000, 16'h8000, 16'h8000, 0);
        push_vertex(24'h7fffff, 24'h800000, 24'h7fffff, 16'h7fff, 16'h7fff, 16'h7fff, 1);
        push_vertex(24'h800000, 24'h800000, 24'h800000, 16'h0001, 0, 0, 0);
        wait_idle();

        // Near-zero matrix: every normal collapses to zero length.
        write_reg(CFG_ROT_ROW_0, '0);
        write_reg(CFG_ROT_ROW_1, '0);
        write_reg(CFG_ROT_ROW_2, {16'h0, 16'h0, 16'h0001});
        push_vertex(24'h123456, 24'h654321, 24'h7fffff, 16'h7fff, 16'h8000, 16'h0007, 1);
        push_vertex(24'h000000, 24'h000000, 24'h000000, 16'h1234, 16'h4321, 16'h0001, 0);
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // One phase runs with no stalls at all.
            stall_pct = (ph == 3) ? 0 : 25;
            for (int r = 0; r < 3; r++)
            begin
                row = {rand_coef(), rand_coef(), rand_coef()};
                if (ph % 3 == 0)
                    row = CFG_DATA_W'({$urandom, $urandom});
                write_reg(cfg_index_t'(r), row);
            end
            write_reg(CFG_PIVOT_X, CFG_DATA_W'({$urandom, $urandom}));
            write_reg(CFG_PIVOT_Y, {24'h0, rand_pos()});
            write_reg(CFG_PIVOT_Z, {24'hffffff, rand_pos()});
            for (int k = 0; k < PHASE_LEN; k++)
                push_vertex(rand_pos(), rand_pos(), rand_pos(),
                            rand_norm(), rand_norm(), rand_norm(), 1'($urandom));
            wait_idle();
        end

        if (!failed)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
